/* sv/jrpd_pkg.sv */
package jrpd_pkg;

    localparam int unsigned JOINTS_DEF = 7;

    // Operation codes
    localparam logic [2:0] OP_CONTROL = 3'd0;
    localparam logic [2:0] OP_START   = 3'd1;
    localparam logic [2:0] OP_GOAL    = 3'd2;
    localparam logic [2:0] OP_STIFF   = 3'd3;
    localparam logic [2:0] OP_DAMP    = 3'd4;

    // Configuration register indexes
    localparam logic [1:0] REG_DURATION  = 2'd0;
    localparam logic [1:0] REG_TOLERANCE = 2'd1;
    localparam logic [1:0] REG_HOLD      = 2'd2;

    localparam logic [31:0] DURATION_RST  = 32'd10000000;
    localparam logic [15:0] TOLERANCE_RST = 16'd655;

    localparam logic [16:0] FRAC_ONE  = 17'h10000;
    localparam int unsigned DIV_STEPS = 16;

    typedef struct packed {
        logic capture;
        logic elapse;
        logic div_init;
        logic div_step;
        logic ramp;
        logic err;
        logic mul_a;
        logic mul_b;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic in_ctrl;
        logic need_ramp;
        logic div_hit;
        logic div_last;
        logic out_free;
    } t_status;

endpackage

/* sv/jrpd_if.sv */
interface jrpd_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  op;
    logic [2:0]  joint;
    logic signed [31:0] position;
    logic signed [31:0] velocity;
    logic [19:0] tick_us;
    modport source (output valid, op, joint, position, velocity, tick_us, input ready);
    modport sink   (input valid, op, joint, position, velocity, tick_us, output ready);
endinterface

interface jrpd_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  joint_out;
    logic signed [31:0] torque;
    logic        finished;
    modport source (output valid, joint_out, torque, finished, input ready);
    modport sink   (input valid, joint_out, torque, finished, output ready);
endinterface

interface jrpd_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [31:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* sv/joint_ramp_pd_controller.sv */
// Channel  Dir  Beat contents
// i_in     in   op, joint, position, velocity, tick_us
// o_out    out  joint_out, torque, finished
// i_cfg    in   index, data (register write)
//
// Load beats and ignored beats leave the controller idle. A control beat
// holds the input until its result is loaded; while the ramp runs, joint 0
// also runs the restoring divider, one quotient bit a cycle, which is skipped
// once the ramp has ended; once the move is done, joint 0 runs like the rest.
// Synchronous active-low reset clears tables and motion state and resets config.
// A result waiting in the output register holds the next control beat in its
// last stage, and the input stays blocked until that result leaves.
module joint_ramp_pd_controller #(
    parameter int unsigned JOINTS = jrpd_pkg::JOINTS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    jrpd_in_if.sink    i_in,
    jrpd_out_if.source o_out,
    jrpd_cfg_if.sink   i_cfg
);

    jrpd_pkg::t_cmd    cmd;
    jrpd_pkg::t_status st;

    jrpd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_st       (st),
        .o_cmd      (cmd)
    );

    jrpd_dp #(.JOINTS(JOINTS)) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_out   (o_out),
        .i_cfg   (i_cfg),
        .i_cmd   (cmd),
        .o_st    (st)
    );

endmodule

/* sv/jrpd_ctrl.sv */
module jrpd_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  jrpd_pkg::t_status i_st,
    output jrpd_pkg::t_cmd    o_cmd
);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_ELAP  = 9'b000000010,
        S_DIVI  = 9'b000000100,
        S_DIV   = 9'b000001000,
        S_RAMP  = 9'b000010000,
        S_ERR   = 9'b000100000,
        S_MULA  = 9'b001000000,
        S_MULB  = 9'b010000000,
        S_OUT   = 9'b100000000
    } t_state;

    t_state r_state, n_state;

    // Sequence one control beat through the datapath
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                o_cmd.capture = i_in_valid;
                if (i_in_valid && i_st.in_ctrl) begin
                    if (i_st.need_ramp) n_state = S_ELAP;
                    else                n_state = S_RAMP;
                end
            end
            S_ELAP: begin
                o_cmd.elapse = 1'b1;
                n_state = S_DIVI;
            end
            S_DIVI: begin
                o_cmd.div_init = 1'b1;
                n_state = i_st.div_hit ? S_RAMP : S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_st.div_last) n_state = S_RAMP;
            end
            S_RAMP: begin
                o_cmd.ramp = 1'b1;
                n_state = S_ERR;
            end
            S_ERR: begin
                o_cmd.err = 1'b1;
                n_state = S_MULA;
            end
            S_MULA: begin
                o_cmd.mul_a = 1'b1;
                n_state = S_MULB;
            end
            S_MULB: begin
                o_cmd.mul_b = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                // hold until the output register is free
                if (i_st.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

endmodule

/* sv/jrpd_dp.sv */
module jrpd_dp #(
    parameter int unsigned JOINTS = jrpd_pkg::JOINTS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    jrpd_in_if.sink           i_in,
    jrpd_out_if.source        o_out,
    jrpd_cfg_if.sink          i_cfg,
    input  jrpd_pkg::t_cmd    i_cmd,
    output jrpd_pkg::t_status o_st
);

    localparam int unsigned JW = (JOINTS > 1) ? $clog2(JOINTS) : 1;

    logic [31:0] r_duration;
    logic [15:0] r_tolerance;
    logic        r_hold;

    logic signed [31:0] r_start [JOINTS];
    logic signed [31:0] r_goal  [JOINTS];
    logic signed [31:0] r_stiff [JOINTS];
    logic signed [31:0] r_damp  [JOINTS];

    logic [31:0] r_elapsed;
    logic [16:0] r_frac;
    logic [63:0] r_err_sum;
    logic        r_done;

    logic [2:0]         r_joint;
    logic signed [31:0] r_pos;
    logic signed [31:0] r_vel;
    logic [19:0]        r_tick;

    logic [31:0]        r_rem;
    logic [15:0]        r_quo;
    logic [4:0]         r_cnt;
    logic signed [50:0] r_prod;
    logic signed [35:0] r_perr;
    logic [64:0]        r_sq;
    logic signed [67:0] r_a;
    logic signed [63:0] r_b;

    logic               r_out_valid;
    logic [2:0]         r_out_joint;
    logic signed [31:0] r_out_torque;
    logic               r_out_fin;

    logic               in_joint_ok;
    logic [JW-1:0]      in_idx, idx;
    logic [31:0]        dur;
    logic [32:0]        elap_sum;
    logic [32:0]        rem2;
    logic signed [32:0] span;
    logic signed [34:0] ramp_ref;
    logic signed [34:0] ref_val;
    logic signed [32:0] gerr;
    logic [32:0]        gmag;
    logic [65:0]        sum_ext;
    logic signed [68:0] pd_diff;
    logic signed [52:0] pd_shift;
    logic signed [31:0] torque_sat;
    logic [31:0]        tol_sq;
    logic               last_joint;

    assign in_joint_ok = (32'(i_in.joint) < JOINTS);
    assign in_idx      = JW'(i_in.joint);
    assign idx         = JW'(r_joint);
    assign dur         = (r_duration == 32'd0) ? 32'd1 : r_duration;
    assign elap_sum    = {1'b0, r_elapsed} + 33'(r_tick);
    assign rem2        = {r_rem, 1'b0};
    assign span        = 33'(r_goal[idx]) - 33'(r_start[idx]);
    assign ramp_ref    = 35'(r_start[idx]) + 35'(r_prod >>> 16);
    assign ref_val     = !r_done ? ramp_ref : (r_hold ? 35'(r_goal[idx]) : 35'(r_pos));
    assign gerr        = 33'(r_pos) - 33'(r_goal[idx]);
    assign gmag        = gerr[32] ? 33'(-gerr) : 33'(gerr);
    assign sum_ext     = {2'b00, r_err_sum} + {1'b0, r_sq};
    assign pd_diff     = 69'(r_a) - 69'(r_b);
    assign pd_shift    = 53'(pd_diff >>> 16);
    assign tol_sq      = 32'(r_tolerance) * 32'(r_tolerance);
    assign last_joint  = (32'(r_joint) == JOINTS - 1);

    // Saturate torque to the signed 32-bit range
    always_comb begin
        if (pd_shift > 53'sd2147483647)       torque_sat = 32'sh7fffffff;
        else if (pd_shift < -53'sd2147483648) torque_sat = 32'sh80000000;
        else                                  torque_sat = 32'(pd_shift);
    end

    // Status to the controller
    always_comb begin
        o_st.in_ctrl   = (i_in.op == jrpd_pkg::OP_CONTROL) && in_joint_ok;
        o_st.need_ramp = !r_done && (i_in.joint == 3'd0);
        o_st.div_hit   = (r_elapsed >= dur);
        o_st.div_last  = (r_cnt == 5'(jrpd_pkg::DIV_STEPS - 1));
        o_st.out_free  = !r_out_valid || o_out.ready;
    end

    // Configuration registers
    assign i_cfg.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_duration  <= jrpd_pkg::DURATION_RST;
            r_tolerance <= jrpd_pkg::TOLERANCE_RST;
            r_hold      <= 1'b1;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                jrpd_pkg::REG_DURATION:  r_duration  <= i_cfg.data;
                jrpd_pkg::REG_TOLERANCE: r_tolerance <= i_cfg.data[15:0];
                jrpd_pkg::REG_HOLD:      r_hold      <= i_cfg.data[0];
                default: ;
            endcase
        end
    end

    // Table loads on an accepted load beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < JOINTS; i++) begin
                r_start[i] <= '0;
                r_goal[i]  <= '0;
                r_stiff[i] <= '0;
                r_damp[i]  <= '0;
            end
        end else if (i_cmd.capture && in_joint_ok) begin
            case (i_in.op)
                jrpd_pkg::OP_START: r_start[in_idx] <= i_in.position;
                jrpd_pkg::OP_GOAL:  r_goal[in_idx]  <= i_in.position;
                jrpd_pkg::OP_STIFF: r_stiff[in_idx] <= i_in.position;
                jrpd_pkg::OP_DAMP:  r_damp[in_idx]  <= i_in.position;
                default: ;
            endcase
        end
    end

    // Capture the sample fields
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_joint <= i_in.joint;
            r_pos   <= i_in.position;
            r_vel   <= i_in.velocity;
            r_tick  <= i_in.tick_us;
        end
    end

    // Motion state: elapsed time, ramp fraction, error sum, finished flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_elapsed <= '0;
            r_frac    <= '0;
            r_err_sum <= '0;
            r_done    <= 1'b0;
        end else begin
            if (i_cmd.elapse) begin
                r_elapsed <= elap_sum[32] ? 32'hffffffff : elap_sum[31:0];
                r_err_sum <= '0;
            end
            if (i_cmd.div_init && o_st.div_hit) r_frac <= jrpd_pkg::FRAC_ONE;
            if (i_cmd.div_step && o_st.div_last)
                r_frac <= {1'b0, r_quo[14:0], (rem2 >= {1'b0, dur})};
            if (i_cmd.mul_a && !r_done)
                r_err_sum <= (sum_ext[65:64] != 2'b00) ? 64'hffffffffffffffff
                                                       : sum_ext[63:0];
            if (i_cmd.out_load && !r_done && last_joint && (r_err_sum < 64'(tol_sq)))
                r_done <= 1'b1;
        end
    end

    // Restoring divider, one quotient bit a cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.div_init) begin
            r_rem <= r_elapsed;
            r_quo <= '0;
            r_cnt <= '0;
        end else if (i_cmd.div_step) begin
            if (rem2 >= {1'b0, dur}) r_rem <= 32'(rem2 - {1'b0, dur});
            else                     r_rem <= rem2[31:0];
            r_quo <= {r_quo[14:0], (rem2 >= {1'b0, dur})};
            r_cnt <= r_cnt + 5'd1;
        end
    end

    // Multiply pipeline: ramp, error terms, stiffness, damping
    always_ff @(posedge i_clk) begin
        if (i_cmd.ramp)  r_prod <= 51'(span) * $signed({34'd0, r_frac});
        if (i_cmd.err) begin
            r_perr <= 36'(ref_val) - 36'(r_pos);
            r_sq   <= 65'(66'(gmag) * 66'(gmag));
        end
        if (i_cmd.mul_a) r_a <= 68'(r_stiff[idx]) * 68'(r_perr);
        if (i_cmd.mul_b) r_b <= 64'(r_damp[idx]) * 64'(r_vel);
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_joint  <= r_joint;
            r_out_torque <= torque_sat;
            r_out_fin    <= r_done ||
                            (last_joint && (r_err_sum < 64'(tol_sq)));
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.joint_out = r_out_joint;
    assign o_out.torque    = r_out_torque;
    assign o_out.finished  = r_out_fin;

endmodule
